[sv/adaptive_step_error_controller_defines.svh]
// Assertion macros for the adaptive step error controller.
`ifndef ADAPTIVE_STEP_ERROR_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_STEP_ERROR_CONTROLLER_DEFINES_SVH

// Check a property on every clock edge out of reset.
`define ASEC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/asec_pkg.sv]
// Shared types and constants of the adaptive step error controller.
`default_nettype none
package asec_pkg;

  localparam logic [31:0] ONE_Q24   = 32'h0100_0000;
  localparam logic [47:0] RATIO_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] SMALL_R   = 48'd262144;

  // ceil(2^42 / 10), split at bit 32, for the divide by ten
  localparam logic [6:0]  RCP_HI = 7'h66;
  localparam logic [31:0] RCP_LO = 32'h6666_6667;

  localparam int unsigned DIV_BITS = 72;
  localparam int unsigned LIMBS    = 6;
  localparam int unsigned PASSES   = 6;
  localparam int unsigned FBIT_TOP = 24;

  localparam logic [1:0] CFG_DIPOLE = 2'd0;
  localparam logic [1:0] CFG_MINTOL = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLR = 2'd0,
    CMD_UPD = 2'd1,
    CMD_ERR = 2'd2,
    CMD_QRY = 2'd3
  } cmd_t;

  typedef enum logic {
    DV_ERR = 1'b0,
    DV_QRY = 1'b1
  } dsel_t;

  typedef struct packed {
    logic       load_in;
    logic       sweep_we;
    logic       sweep_one;
    logic       upd_write;
    logic       clr_max;
    logic       sq_en;
    logic       div_start;
    dsel_t      div_sel;
    logic       div_step;
    logic       erec;
    logic       r_latch;
    logic       f_two;
    logic       f_zero;
    logic       try_init;
    logic       limb_step;
    logic       limb_first;
    logic       limb_last;
    logic       chk;
    logic       mulo;
    logic       ten_load;
    logic       rcp_mul;
    logic       out_load;
    logic [4:0] bit_sel;
  } ctl_t;

endpackage
`default_nettype wire

[sv/asec_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module asec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

[sv/asec_dpath.sv]
// Datapath: config registers, tolerance RAM, serial divider, root search, step product.
`default_nettype none
module asec_dpath #(
  parameter int PARTICLES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_wdata,
  input  wire asec_pkg::ctl_t         ctl,
  input  wire logic [(PARTICLES > 1 ? $clog2(PARTICLES) : 1)-1:0] sweep_addr,
  input  wire logic [9:0]             in_idx,
  input  wire logic [31:0]            in_sample,
  input  wire logic [31:0]            in_old,
  output logic                        r_small,
  output logic [31:0]                 new_step_r,
  output logic [9:0]                  worst_index_r,
  output logic [47:0]                 worst_ratio_r
);
  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  logic        dipole_r;
  logic [31:0] mintol_r, scale_r;
  logic [9:0]  idx_r;
  logic [31:0] sample_r, old_r;
  logic [31:0] tol_r;
  logic [63:0] sq_r;
  logic [47:0] max_r, r_r;
  logic [9:0]  max_idx_r;
  logic [71:0] dq_r;
  logic [31:0] drem_r, dd_r;
  logic        dz_r, dnz_r;
  logic [31:0] w_r [asec_pkg::LIMBS];
  logic [24:0] c_r, carry_r;
  logic        ovf_r;
  logic [25:0] f_r;
  logic [57:0] prod_r;
  logic [37:0] x_r;
  logic [63:0] rl_r;
  logic [39:0] rm_r;
  logic [12:0] rh_r;

  logic [AW-1:0] ram_addr;
  logic          ram_we, upd_we;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [71:0]   div_a;
  logic [31:0]   div_b;
  logic [32:0]   dtrial;
  logic          dge;
  logic [47:0]   qsat;
  logic [61:0]   p9;
  logic [76:0]   rcp_sum;
  logic [56:0]   limb_t;
  logic          fits;

  asec_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_tol_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    upd_we    = ctl.upd_write && dipole_r && (sample_r < mintol_r) && (sample_r < ram_rdata);
    ram_we    = ctl.sweep_we || upd_we;
    ram_addr  = ctl.sweep_we ? sweep_addr : AW'(idx_r);
    ram_wdata = ctl.sweep_we ? (ctl.sweep_one ? asec_pkg::ONE_Q24 : mintol_r) : sample_r;
  end

  always_comb begin
    p9 = 62'({prod_r, 3'b000}) + 62'(prod_r);
    // x * ceil(2^42 / 10) >> 42 is floor(x / 10) for any 38-bit x
    rcp_sum = 77'(rl_r) + {5'b0, rm_r, 32'b0} + {rh_r, 64'b0};
    unique case (ctl.div_sel)
      asec_pkg::DV_ERR: begin
        div_a = {8'b0, sq_r};
        div_b = tol_r;
      end
      asec_pkg::DV_QRY: begin
        div_a = {max_r, 24'b0};
        div_b = scale_r;
      end
    endcase
    dtrial = {drem_r, dq_r[71]};
    dge    = dtrial >= {1'b0, dd_r};
    if (dz_r) begin
      qsat = dnz_r ? asec_pkg::RATIO_MAX : 48'd0;
    end else if (|dq_r[71:48]) begin
      qsat = asec_pkg::RATIO_MAX;
    end else begin
      qsat = dq_r[47:0];
    end
    r_small = qsat <= asec_pkg::SMALL_R;
  end

  always_comb begin
    limb_t = 57'(w_r[0]) * 57'(c_r) + 57'(ctl.limb_first ? 25'd0 : carry_r);
    fits   = !ovf_r && ((w_r[5][31:8] == 24'd0) ||
             ((w_r[5] == 32'd256) && (w_r[4] == 32'd0) && (w_r[3] == 32'd0) &&
              (w_r[2] == 32'd0) && (w_r[1] == 32'd0) && (w_r[0] == 32'd0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dipole_r  <= 1'b0;
      mintol_r  <= asec_pkg::ONE_Q24;
      scale_r   <= asec_pkg::ONE_Q24;
      max_r     <= '0;
      max_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          asec_pkg::CFG_DIPOLE: dipole_r <= cfg_wdata[0];
          asec_pkg::CFG_MINTOL: mintol_r <= cfg_wdata;
          asec_pkg::CFG_SCALE:  scale_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.clr_max) begin
        max_r <= '0;
      end else if (ctl.erec && (qsat > max_r)) begin
        max_r     <= qsat;
        max_idx_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      idx_r    <= in_idx;
      sample_r <= in_sample;
      old_r    <= in_old;
    end
    if (ctl.sq_en) begin
      tol_r <= dipole_r ? ram_rdata : mintol_r;
      sq_r  <= 64'(sample_r) * 64'(sample_r);
    end
    if (ctl.div_start) begin
      dq_r   <= div_a;
      dd_r   <= div_b;
      drem_r <= '0;
      dz_r   <= div_b == 32'd0;
      dnz_r  <= div_a != 72'd0;
    end else if (ctl.div_step) begin
      drem_r <= dge ? 32'(dtrial - {1'b0, dd_r}) : dtrial[31:0];
      dq_r   <= {dq_r[70:0], dge};
    end
    if (ctl.r_latch) begin
      r_r <= qsat;
    end
    if (ctl.f_two) begin
      f_r <= 26'd1 << 25;
    end else if (ctl.f_zero) begin
      f_r <= '0;
    end else if (ctl.chk && fits) begin
      f_r <= {1'b0, c_r};
    end
    if (ctl.try_init) begin
      w_r[0] <= r_r[31:0];
      w_r[1] <= {16'b0, r_r[47:32]};
      for (int i = 2; i < asec_pkg::LIMBS; i++) begin
        w_r[i] <= '0;
      end
      c_r   <= f_r[24:0] | (25'd1 << ctl.bit_sel);
      ovf_r <= 1'b0;
    end else if (ctl.limb_step) begin
      // rotate limbs through the multiplier, lowest first
      for (int i = 0; i < asec_pkg::LIMBS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[asec_pkg::LIMBS-1] <= limb_t[31:0];
      carry_r <= limb_t[56:32];
      if (ctl.limb_last && (limb_t[56:32] != 25'd0)) begin
        ovf_r <= 1'b1;
      end
    end
    if (ctl.mulo) begin
      prod_r <= 58'(old_r) * 58'(f_r);
    end
    if (ctl.ten_load) begin
      x_r <= p9[61:24];
    end
    if (ctl.rcp_mul) begin
      rl_r <= 64'(x_r[31:0]) * 64'(asec_pkg::RCP_LO);
      rm_r <= 40'(x_r[31:0]) * 40'(asec_pkg::RCP_HI) +
              40'(x_r[37:32]) * 40'(asec_pkg::RCP_LO);
      rh_r <= 13'(x_r[37:32]) * 13'(asec_pkg::RCP_HI);
    end
    if (ctl.out_load) begin
      new_step_r    <= (|rcp_sum[76:74]) ? 32'hFFFF_FFFF : rcp_sum[73:42];
      worst_index_r <= max_idx_r;
      worst_ratio_r <= r_r;
    end
  end
endmodule
`default_nettype wire

[sv/asec_ctrl.sv]
// Controller: sequences commands, RAM sweeps, divider runs and the root search.
`default_nettype none
module asec_ctrl #(
  parameter int PARTICLES = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     in_cmd,
  input  wire logic [9:0]     in_idx,
  input  wire logic           out_tready,
  output logic                out_tvalid,
  input  wire logic           r_small,
  output asec_pkg::ctl_t      ctl,
  output logic [(PARTICLES > 1 ? $clog2(PARTICLES) : 1)-1:0] sweep_addr
);
  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int CW = (AW > 7) ? AW : 7;

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_RST   = 18'b000000000000000010,
    S_SWEEP = 18'b000000000000000100,
    S_RD    = 18'b000000000000001000,
    S_UPD   = 18'b000000000000010000,
    S_SQ    = 18'b000000000000100000,
    S_EDIV  = 18'b000000000001000000,
    S_QDIV  = 18'b000000000010000000,
    S_DIV   = 18'b000000000100000000,
    S_EREC  = 18'b000000001000000000,
    S_QR    = 18'b000000010000000000,
    S_TRY   = 18'b000000100000000000,
    S_LIMB  = 18'b000001000000000000,
    S_CHK   = 18'b000010000000000000,
    S_MULO  = 18'b000100000000000000,
    S_TEN   = 18'b001000000000000000,
    S_RCP   = 18'b010000000000000000,
    S_OUT   = 18'b100000000000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  asec_pkg::cmd_t cmd_r, cmd_nxt;
  logic [2:0]     limb_r, limb_nxt, pass_r, pass_nxt;
  logic [4:0]     bit_r, bit_nxt;
  logic           outv_r, outv_nxt;
  logic           idx_ok;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = outv_r;
  assign sweep_addr = cnt_r[AW-1:0];
  assign idx_ok     = 17'(in_idx) < 17'(PARTICLES);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd_nxt     = cmd_r;
    limb_nxt    = limb_r;
    pass_nxt    = pass_r;
    bit_nxt     = bit_r;
    outv_nxt    = outv_r;
    ctl         = '0;
    ctl.bit_sel = bit_r;
    if (outv_r && out_tready) begin
      outv_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load_in = 1'b1;
          cmd_nxt     = asec_pkg::cmd_t'(in_cmd);
          cnt_nxt     = '0;
          unique case (asec_pkg::cmd_t'(in_cmd))
            asec_pkg::CMD_CLR: begin
              ctl.clr_max = 1'b1;
              state_nxt   = S_SWEEP;
            end
            asec_pkg::CMD_UPD, asec_pkg::CMD_ERR: state_nxt = idx_ok ? S_RD : S_IDLE;
            asec_pkg::CMD_QRY: state_nxt = S_QDIV;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RST, S_SWEEP: begin
        ctl.sweep_we  = 1'b1;
        ctl.sweep_one = state_r == S_RST;
        if (cnt_r == CW'(PARTICLES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RD: state_nxt = (cmd_r == asec_pkg::CMD_UPD) ? S_UPD : S_SQ;
      S_UPD: begin
        ctl.upd_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SQ: begin
        ctl.sq_en = 1'b1;
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = asec_pkg::DV_ERR;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_QDIV: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = asec_pkg::DV_QRY;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_r == CW'(asec_pkg::DIV_BITS - 1)) begin
          if (cmd_r == asec_pkg::CMD_ERR) begin
            state_nxt = S_EREC;
          end else begin
            state_nxt = S_QR;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EREC: begin
        ctl.erec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QR: begin
        ctl.r_latch = 1'b1;
        if (r_small) begin
          ctl.f_two = 1'b1;
          state_nxt = S_MULO;
        end else begin
          ctl.f_zero = 1'b1;
          bit_nxt    = 5'(asec_pkg::FBIT_TOP);
          state_nxt  = S_TRY;
        end
      end
      S_TRY: begin
        ctl.try_init = 1'b1;
        limb_nxt     = '0;
        pass_nxt     = '0;
        state_nxt    = S_LIMB;
      end
      S_LIMB: begin
        ctl.limb_step  = 1'b1;
        ctl.limb_first = limb_r == 3'd0;
        ctl.limb_last  = limb_r == 3'(asec_pkg::LIMBS - 1);
        if (limb_r == 3'(asec_pkg::LIMBS - 1)) begin
          limb_nxt = '0;
          pass_nxt = pass_r + 1'b1;
          if (pass_r == 3'(asec_pkg::PASSES - 1)) begin
            state_nxt = S_CHK;
          end
        end else begin
          limb_nxt = limb_r + 1'b1;
        end
      end
      S_CHK: begin
        ctl.chk = 1'b1;
        if (bit_r == 5'd0) begin
          state_nxt = S_MULO;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_TRY;
        end
      end
      S_MULO: begin
        ctl.mulo  = 1'b1;
        state_nxt = S_TEN;
      end
      S_TEN: begin
        ctl.ten_load = 1'b1;
        state_nxt    = S_RCP;
      end
      S_RCP: begin
        ctl.rcp_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold until the output slot is free
        if (!outv_r || out_tready) begin
          ctl.out_load = 1'b1;
          outv_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST;
      cnt_r   <= '0;
      cmd_r   <= asec_pkg::CMD_CLR;
      limb_r  <= '0;
      pass_r  <= '0;
      bit_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      limb_r  <= limb_nxt;
      pass_r  <= pass_nxt;
      bit_r   <= bit_nxt;
      outv_r  <= outv_nxt;
    end
  end
endmodule
`default_nettype wire

[sv/adaptive_step_error_controller.sv]
// Top level of the adaptive step error controller.
//
//   channel  | direction | transfer on               | payload
//   in_      | slave     | in_tvalid & in_tready     | tuser command, tdata index/sample/old
//   out_     | master    | out_tvalid & out_tready   | tdata new_step/worst_index/worst_ratio
//   cfg_     | write     | cfg_we                    | cfg_index, cfg_wdata
//
// After reset the tolerance RAM is swept to 1.0 with in_tready low.
// Clear: the RAM is swept one row per cycle. Error: one 72-step serial divide. Query: one
// 72-step divide, then a root search over 25 bits, each bit tried with the limb-serial
// 32x25 multiplier, then a multiply, a times-nine and a divide by ten to scale by 0.9;
// the root search is skipped when the ratio is at most 1/64.
// A finished result waits in the output register; a query stalls only if it is still held.
`default_nettype none
`include "adaptive_step_error_controller_defines.svh"
module adaptive_step_error_controller #(
  parameter int PARTICLES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // particle_index[9:0], sample_value[41:10], old_step[73:42]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // new_step[31:0], worst_index[41:32], worst_ratio[89:42]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  asec_pkg::ctl_t ctl;
  logic [AW-1:0]  sweep_addr;
  logic           r_small;
  logic [31:0]    new_step;
  logic [9:0]     worst_index;
  logic [47:0]    worst_ratio;

  asec_ctrl #(.PARTICLES(PARTICLES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_idx     (in_tdata[9:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .r_small    (r_small),
    .ctl        (ctl),
    .sweep_addr (sweep_addr)
  );

  asec_dpath #(.PARTICLES(PARTICLES)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .ctl           (ctl),
    .sweep_addr    (sweep_addr),
    .in_idx        (in_tdata[9:0]),
    .in_sample     (in_tdata[41:10]),
    .in_old        (in_tdata[73:42]),
    .r_small       (r_small),
    .new_step_r    (new_step),
    .worst_index_r (worst_index),
    .worst_ratio_r (worst_ratio)
  );

  assign out_tdata = {6'b0, worst_ratio, worst_index, new_step};

  `ASEC_ASSERT_RST(a_ram_write_busy, clk, rst_n, (ctl.sweep_we || ctl.upd_write) |-> !in_tready, "RAM write while accepting input")
  `ASEC_ASSERT_RST(a_out_slot_free, clk, rst_n, ctl.out_load |-> (!out_tvalid || out_tready), "result overwrites a held result")
  `ASEC_ASSERT_RST(a_div_busy, clk, rst_n, ctl.div_start |=> !in_tready, "input accepted during a divide")
endmodule
`default_nettype wire
